// ===== src/asi_pkg.sv =====
// Shared types, constants and helper functions of the arc segment interpolator.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package asi_pkg;

  // Angles are 2^29 per radian, held in ANG_W-bit signed words.
  localparam int ANG_W = 34;
  // CORDIC datapath word, wide enough for the gain on a 33-bit vector.
  localparam int XY_W = 36;
  localparam int K_W = 5;

  localparam logic signed [ANG_W-1:0] ANG_PI = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd843314857;
  localparam logic [31:0] RADIUS_MIN = 32'd6554;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic [1:0] CFG_ABSOLUTE_MODE = 2'd0;
  localparam logic [1:0] CFG_WORK_OFFSET_X = 2'd1;
  localparam logic [1:0] CFG_WORK_OFFSET_Y = 2'd2;
  localparam logic [1:0] CFG_SPEED_SCALE = 2'd3;

  // One queued command, resolved by the front end.
  typedef struct packed {
    logic              is_tick;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] off_i;
    logic signed [31:0] off_j;
    logic              cw;
    logic [31:0]       feed;
  } cmd_t;

  typedef struct packed {
    logic                     start;
    logic                     vector;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [ANG_W-1:0]  z;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [ANG_W-1:0]  z;
  } cordic_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? n : v;
  endfunction

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [K_W-1:0] k);
    logic signed [ANG_W-1:0] a;
    unique case (k)
      5'd0:  a = 34'sd421657428;
      5'd1:  a = 34'sd248918915;
      5'd2:  a = 34'sd131521918;
      5'd3:  a = 34'sd66762579;
      5'd4:  a = 34'sd33510843;
      5'd5:  a = 34'sd16771758;
      5'd6:  a = 34'sd8387925;
      5'd7:  a = 34'sd4194219;
      5'd8:  a = 34'sd2097141;
      5'd9:  a = 34'sd1048575;
      5'd10: a = 34'sd524288;
      5'd11: a = 34'sd262144;
      5'd12: a = 34'sd131072;
      5'd13: a = 34'sd65536;
      5'd14: a = 34'sd32768;
      5'd15: a = 34'sd16384;
      5'd16: a = 34'sd8192;
      5'd17: a = 34'sd4096;
      5'd18: a = 34'sd2048;
      5'd19: a = 34'sd1024;
      5'd20: a = 34'sd512;
      5'd21: a = 34'sd256;
      5'd22: a = 34'sd128;
      5'd23: a = 34'sd64;
      5'd24: a = 34'sd32;
      5'd25: a = 34'sd16;
      5'd26: a = 34'sd8;
      5'd27: a = 34'sd4;
      5'd28: a = 34'sd2;
      5'd29: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== src/asi_front.sv =====
// Front end: classifies each input item and resolves end point and feed.
// Depends on asi_pkg.
`default_nettype none

module asi_front (
  input  wire logic               req_type_i,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic signed [31:0] word_x_i,
  input  wire logic signed [31:0] word_y_i,
  input  wire logic               has_x_i,
  input  wire logic               has_y_i,
  input  wire logic signed [31:0] off_i_i,
  input  wire logic signed [31:0] off_j_i,
  input  wire logic               clockwise_i,
  input  wire logic [23:0]        feed_rate_i,
  input  wire logic               absolute_mode_i,
  input  wire logic signed [31:0] work_offset_x_i,
  input  wire logic signed [31:0] work_offset_y_i,
  input  wire logic [15:0]        speed_scale_i,
  output asi_pkg::cmd_t           cmd_o
);

  logic [39:0] feed_prod;
  logic signed [31:0] end_x, end_y;

  assign feed_prod = 40'(feed_rate_i) * 40'(speed_scale_i);

  always_comb begin
    if (absolute_mode_i) begin
      end_x = has_x_i ? asi_pkg::sat32(40'(word_x_i) + 40'(work_offset_x_i)) : start_x_i;
      end_y = has_y_i ? asi_pkg::sat32(40'(word_y_i) + 40'(work_offset_y_i)) : start_y_i;
    end else begin
      end_x = asi_pkg::sat32(40'(start_x_i) + (has_x_i ? 40'(word_x_i) : 40'sd0));
      end_y = asi_pkg::sat32(40'(start_y_i) + (has_y_i ? 40'(word_y_i) : 40'sd0));
    end
  end

  always_comb begin
    cmd_o.is_tick = req_type_i;
    cmd_o.start_x = start_x_i;
    cmd_o.start_y = start_y_i;
    cmd_o.end_x   = end_x;
    cmd_o.end_y   = end_y;
    cmd_o.off_i   = off_i_i;
    cmd_o.off_j   = off_j_i;
    cmd_o.cw      = clockwise_i;
    cmd_o.feed    = feed_prod[39:8];
  end

endmodule

`default_nettype wire

// ===== src/asi_queue.sv =====
// Two-entry command queue between the front end and the sequencer.
// Depends on asi_pkg for the command type.
`default_nettype none

module asi_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  asi_pkg::cmd_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output asi_pkg::cmd_t data_o,
  input  wire logic     pop_i
);

  asi_pkg::cmd_t mem_q [2];
  logic wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = do_push ? !wptr_q : wptr_q;
    rptr_d  = do_pop ? !rptr_q : rptr_q;
    count_d = count_q + (do_push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/asi_cordic.sv =====
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on asi_pkg for angle constants, the arctangent table and the request types.
`default_nettype none

module asi_cordic #(
  parameter int ITERATIONS = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  asi_pkg::cordic_req_t req_i,
  output asi_pkg::cordic_rsp_t rsp_o
);

  localparam logic [asi_pkg::K_W-1:0] K_LAST = asi_pkg::K_W'(ITERATIONS - 1);

  logic busy_q, busy_d, done_q, done_d, vec_q, vec_d;
  logic [asi_pkg::K_W-1:0] k_q, k_d;
  logic signed [asi_pkg::XY_W-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [asi_pkg::ANG_W-1:0] z_q, z_d, atan_k;
  logic sel;

  assign dx = y_q >>> k_q;
  assign dy = x_q >>> k_q;
  assign atan_k = asi_pkg::atan_lut(k_q);
  assign sel = vec_q ? !(y_q > 0) : (z_q >= 0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    vec_d  = vec_q;
    k_d    = k_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (req_i.start) begin
      vec_d  = req_i.vector;
      k_d    = '0;
      busy_d = 1'b1;
      x_d    = req_i.x;
      y_d    = req_i.y;
      z_d    = req_i.z;
      if (req_i.vector) begin
        if (req_i.x == 0 && req_i.y == 0) begin
          // A null vector has angle zero; no iterations are run.
          busy_d = 1'b0;
          done_d = 1'b1;
          z_d    = '0;
        end else if (req_i.x < 0) begin
          if (req_i.y >= 0) begin
            x_d = req_i.y;
            y_d = -req_i.x;
            z_d = asi_pkg::ANG_HALF_PI;
          end else begin
            x_d = -req_i.y;
            y_d = req_i.x;
            z_d = -asi_pkg::ANG_HALF_PI;
          end
        end
      end else begin
        if (req_i.z > asi_pkg::ANG_HALF_PI) begin
          x_d = '0;
          y_d = req_i.x;
          z_d = req_i.z - asi_pkg::ANG_HALF_PI;
        end else if (req_i.z < -asi_pkg::ANG_HALF_PI) begin
          x_d = '0;
          y_d = -req_i.x;
          z_d = req_i.z + asi_pkg::ANG_HALF_PI;
        end
      end
    end else if (busy_q) begin
      if (sel) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_k;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_k;
      end
      k_d = k_q + 1'b1;
      if (k_q == K_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
      vec_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
      vec_q  <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.x    = x_q;
    rsp_o.y    = y_q;
    rsp_o.z    = z_q;
    if (vec_q) begin
      if (z_q > asi_pkg::ANG_PI) begin
        rsp_o.z = asi_pkg::ANG_PI;
      end else if (z_q < -asi_pkg::ANG_PI) begin
        rsp_o.z = -asi_pkg::ANG_PI;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/asi_back.sv =====
// Back end sequencer: radius, angles, segment count and per-tick points, plus output register.
// Depends on asi_pkg; drives the shared asi_cordic unit through its request struct.
`default_nettype none

module asi_back #(
  parameter int SEG_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  asi_pkg::cmd_t           q_data_i,
  output logic                    q_pop_o,
  output asi_pkg::cordic_req_t    cor_req_o,
  input  asi_pkg::cordic_rsp_t    cor_rsp_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      point_x_o,
  output logic signed [31:0]      point_y_o,
  output logic [31:0]             move_feed_o,
  output logic                    last_point_o,
  output logic                    linear_fallback_o
);

  localparam int VW = SEG_BITS + 34;
  localparam logic [24:0] SEG_MAX = (25'd1 << SEG_BITS) - 25'd1;

  typedef enum logic [15:0] {
    S_IDLE     = 16'b0000_0000_0000_0001,
    S_SQ_I     = 16'b0000_0000_0000_0010,
    S_SQ_J     = 16'b0000_0000_0000_0100,
    S_SQRT     = 16'b0000_0000_0000_1000,
    S_CHECK    = 16'b0000_0000_0001_0000,
    S_VEC1     = 16'b0000_0000_0010_0000,
    S_VEC2     = 16'b0000_0000_0100_0000,
    S_SEG_MUL  = 16'b0000_0000_1000_0000,
    S_SEGS     = 16'b0000_0001_0000_0000,
    S_DIV      = 16'b0000_0010_0000_0000,
    S_STEP     = 16'b0000_0100_0000_0000,
    S_EMIT_LIN = 16'b0000_1000_0000_0000,
    S_TADV     = 16'b0001_0000_0000_0000,
    S_TANG     = 16'b0010_0000_0000_0000,
    S_ROT      = 16'b0100_0000_0000_0000,
    S_EMIT_PT  = 16'b1000_0000_0000_0000
  } state_e;

  state_e state_q, state_d;
  asi_pkg::cmd_t cmd_q, cmd_d;
  logic active_q, active_d;
  logic [4:0] cnt_q, cnt_d;
  logic [63:0] sq_q, sq_d, sn_q, sn_d, prod_q, prod_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d, radius_q, radius_d, x0_q, x0_d, dq_q, dq_d, feed_q, feed_d;
  logic signed [31:0] cx_q, cx_d, cy_q, cy_d, first_q, first_d, step_q, step_d;
  logic signed [33:0] diff_q, diff_d, r_q, r_d;
  logic signed [VW-1:0] v_q, v_d;
  logic [SEG_BITS-1:0] total_q, total_d, index_q, index_d, drem_q, drem_d;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d, out_lin_q, out_lin_d;
  logic signed [31:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [31:0] out_feed_q, out_feed_d;

  logic out_free;
  logic [35:0] rem_sh, trial;
  logic [61:0] gain_prod;
  logic [64:0] seg_sum;
  logic [24:0] seg_raw, seg_sat;
  logic [SEG_BITS:0] div_sh, div_sub;
  logic signed [33:0] ea, q_s, st, rt, ang_c;
  logic [31:0] adiff;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rem_sh = {rem_q, sn_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign gain_prod = 62'(root_q) * 62'(asi_pkg::INV_GAIN_Q30);
  assign seg_sum = {1'b0, prod_q} + 65'h1FFF_FFFF_FFFF;
  assign seg_raw = {5'd0, seg_sum[64:45]};
  assign div_sh = {drem_q, dq_q[31]};
  assign div_sub = div_sh - {1'b0, total_q};
  assign adiff = 32'(diff_q[33] ? -diff_q : diff_q);
  assign q_s = $signed({2'b00, dq_q});

  always_comb begin
    if (seg_raw > SEG_MAX) begin
      seg_sat = SEG_MAX;
    end else if (seg_raw == 25'd0) begin
      seg_sat = 25'd1;
    end else begin
      seg_sat = seg_raw;
    end
  end

  // End angle moved by one turn into the commanded direction.
  always_comb begin
    ea = cor_rsp_i.z;
    if (cmd_q.cw) begin
      if (ea >= 34'(first_q)) ea = ea - asi_pkg::ANG_TWO_PI;
    end else begin
      if (ea <= 34'(first_q)) ea = ea + asi_pkg::ANG_TWO_PI;
    end
  end

  always_comb begin
    st = diff_q[33] ? -q_s : q_s;
    if (st > asi_pkg::ANG_PI) begin
      st = st - asi_pkg::ANG_TWO_PI;
    end else if (st < -asi_pkg::ANG_PI) begin
      st = st + asi_pkg::ANG_TWO_PI;
    end
  end

  // Residue of the running angle, kept in [0, 2pi).
  always_comb begin
    rt = r_q + 34'(step_q);
    if (rt < 0) begin
      rt = rt + asi_pkg::ANG_TWO_PI;
    end else if (rt >= asi_pkg::ANG_TWO_PI) begin
      rt = rt - asi_pkg::ANG_TWO_PI;
    end
  end

  // Truncating remainder takes the sign of the running angle, then wraps into [-pi, pi].
  always_comb begin
    ang_c = (v_q < 0 && r_q != 0) ? r_q - asi_pkg::ANG_TWO_PI : r_q;
    if (ang_c > asi_pkg::ANG_PI) begin
      ang_c = ang_c - asi_pkg::ANG_TWO_PI;
    end else if (ang_c < -asi_pkg::ANG_PI) begin
      ang_c = ang_c + asi_pkg::ANG_TWO_PI;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    active_d   = active_q;
    cnt_d      = cnt_q;
    sq_d       = sq_q;
    sn_d       = sn_q;
    prod_d     = prod_q;
    rem_d      = rem_q;
    root_d     = root_q;
    radius_d   = radius_q;
    x0_d       = x0_q;
    dq_d       = dq_q;
    feed_d     = feed_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    first_d    = first_q;
    step_d     = step_q;
    diff_d     = diff_q;
    r_d        = r_q;
    v_d        = v_q;
    total_d    = total_q;
    index_d    = index_q;
    drem_d     = drem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    out_feed_d = out_feed_q;
    out_last_d = out_last_q;
    out_lin_d  = out_lin_q;
    q_pop_o    = 1'b0;
    cor_req_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          if (q_data_i.is_tick) begin
            state_d = active_q ? S_TADV : S_IDLE;
          end else begin
            feed_d  = q_data_i.feed;
            state_d = S_SQ_I;
          end
        end
      end
      S_SQ_I: begin
        sq_d    = 64'(asi_pkg::abs32(cmd_q.off_i)) * 64'(asi_pkg::abs32(cmd_q.off_i));
        state_d = S_SQ_J;
      end
      S_SQ_J: begin
        sn_d    = sq_q + 64'(asi_pkg::abs32(cmd_q.off_j)) * 64'(asi_pkg::abs32(cmd_q.off_j));
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (rem_sh >= trial) begin
          rem_d  = 34'(rem_sh - trial);
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = rem_sh[33:0];
          root_d = {root_q[30:0], 1'b0};
        end
        sn_d  = {sn_q[61:0], 2'b00};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = S_CHECK;
      end
      S_CHECK: begin
        radius_d = root_q;
        if (root_q < asi_pkg::RADIUS_MIN) begin
          active_d = 1'b0;
          state_d  = S_EMIT_LIN;
        end else begin
          cx_d = asi_pkg::sat32(40'(cmd_q.start_x) + 40'(cmd_q.off_i));
          cy_d = asi_pkg::sat32(40'(cmd_q.start_y) + 40'(cmd_q.off_j));
          x0_d = gain_prod[61:30];
          cor_req_o.start  = 1'b1;
          cor_req_o.vector = 1'b1;
          cor_req_o.x      = -36'(cmd_q.off_i);
          cor_req_o.y      = -36'(cmd_q.off_j);
          cor_req_o.z      = '0;
          state_d = S_VEC1;
        end
      end
      S_VEC1: begin
        if (cor_rsp_i.done) begin
          first_d = cor_rsp_i.z[31:0];
          cor_req_o.start  = 1'b1;
          cor_req_o.vector = 1'b1;
          cor_req_o.x      = 36'(cmd_q.end_x) - 36'(cx_q);
          cor_req_o.y      = 36'(cmd_q.end_y) - 36'(cy_q);
          cor_req_o.z      = '0;
          state_d = S_VEC2;
        end
      end
      S_VEC2: begin
        if (cor_rsp_i.done) begin
          diff_d  = ea - 34'(first_q);
          state_d = S_SEG_MUL;
        end
      end
      S_SEG_MUL: begin
        prod_d  = 64'(adiff) * 64'(radius_q);
        state_d = S_SEGS;
      end
      S_SEGS: begin
        total_d = seg_sat[SEG_BITS-1:0];
        index_d = '0;
        dq_d    = adiff;
        drem_d  = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_sh >= {1'b0, total_q}) begin
          drem_d = div_sub[SEG_BITS-1:0];
          dq_d   = {dq_q[30:0], 1'b1};
        end else begin
          drem_d = div_sh[SEG_BITS-1:0];
          dq_d   = {dq_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = S_STEP;
      end
      S_STEP: begin
        step_d   = st[31:0];
        v_d      = VW'(first_q);
        r_d      = first_q[31] ? 34'(first_q) + asi_pkg::ANG_TWO_PI : 34'(first_q);
        active_d = 1'b1;
        state_d  = S_IDLE;
      end
      S_EMIT_LIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_x_d     = cmd_q.end_x;
          out_y_d     = cmd_q.end_y;
          out_feed_d  = feed_q;
          out_last_d  = 1'b1;
          out_lin_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_TADV: begin
        index_d = index_q + 1'b1;
        v_d     = v_q + VW'(step_q);
        r_d     = rt;
        state_d = S_TANG;
      end
      S_TANG: begin
        cor_req_o.start  = 1'b1;
        cor_req_o.vector = 1'b0;
        cor_req_o.x      = 36'(x0_q);
        cor_req_o.y      = '0;
        cor_req_o.z      = ang_c;
        state_d = S_ROT;
      end
      S_ROT: begin
        if (cor_rsp_i.done) state_d = S_EMIT_PT;
      end
      S_EMIT_PT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_x_d     = asi_pkg::sat32(40'(cx_q) + 40'(cor_rsp_i.x));
          out_y_d     = asi_pkg::sat32(40'(cy_q) + 40'(cor_rsp_i.y));
          out_feed_d  = feed_q;
          out_last_d  = (index_q >= total_q);
          out_lin_d   = 1'b0;
          active_d    = (index_q < total_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      index_q     <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      index_q     <= index_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    sq_q       <= sq_d;
    sn_q       <= sn_d;
    prod_q     <= prod_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    radius_q   <= radius_d;
    x0_q       <= x0_d;
    dq_q       <= dq_d;
    feed_q     <= feed_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    first_q    <= first_d;
    step_q     <= step_d;
    diff_q     <= diff_d;
    r_q        <= r_d;
    v_q        <= v_d;
    drem_q     <= drem_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_feed_q <= out_feed_d;
    out_last_q <= out_last_d;
    out_lin_q  <= out_lin_d;
  end

  assign out_valid_o       = out_valid_q;
  assign point_x_o         = out_x_q;
  assign point_y_o         = out_y_q;
  assign move_feed_o       = out_feed_q;
  assign last_point_o      = out_last_q;
  assign linear_fallback_o = out_lin_q;

endmodule

`default_nettype wire

// ===== src/arc_segment_interpolator_top.sv =====
// Top level of the circular arc interpolator: configuration registers and module wiring.
// Depends on asi_pkg, asi_front, asi_queue, asi_cordic and asi_back.
`default_nettype none

// The block accepts two kinds of item. A start item carries the pen position, the optional
// X/Y words, the I/J centre offsets, the direction and the feed; it resolves the end point
// (absolute with the work offset, or relative to the pen), the centre and the radius. A
// radius under 0.1 mm gives one straight move to the end point at once. Otherwise the start
// and end angles are found with a CORDIC, the segment count is ceil(arc length / 1 mm),
// saturated at 2^SEGMENT_COUNT_BITS - 1, and the start item gives no result. Each tick item
// then gives the next point on the circle; the final point has last_point set, and a tick
// with no arc in progress gives nothing. A two-entry queue sits between the input side and
// the sequencer, and the result waits in an output register, so while a result is stalled
// the queue still takes two items and the sequencer works on a third. The work is done by the
// single sequencer and its shared iterative CORDIC: a start item passes through two
// multiplies, a 32-step square root, two vectoring passes of the CORDIC, the segment count
// and a 32-step divide; the straight-move case has its result after the two multiplies, the
// 32-step square root and the radius check; a tick item advances the angle, runs one
// rotation pass and then writes the output register. Configuration must be written by the
// user only while no item is in flight; the block itself does not enforce this.

module arc_segment_interpolator_top #(
  parameter int SEGMENT_COUNT_BITS = 16,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic signed [31:0] word_x_i,
  input  wire logic signed [31:0] word_y_i,
  input  wire logic               has_x_i,
  input  wire logic               has_y_i,
  input  wire logic signed [31:0] off_i_i,
  input  wire logic signed [31:0] off_j_i,
  input  wire logic               clockwise_i,
  input  wire logic [23:0]        feed_rate_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      point_x_o,
  output logic signed [31:0]      point_y_o,
  output logic [31:0]             move_feed_o,
  output logic                    last_point_o,
  output logic                    linear_fallback_o
);

  logic absolute_mode_q;
  logic signed [31:0] work_offset_x_q, work_offset_y_q;
  logic [15:0] speed_scale_q;

  // Configuration writes land directly; the register index selects the target.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      absolute_mode_q <= 1'b1;
      work_offset_x_q <= '0;
      work_offset_y_q <= '0;
      speed_scale_q   <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        asi_pkg::CFG_ABSOLUTE_MODE: absolute_mode_q <= cfg_data_i[0];
        asi_pkg::CFG_WORK_OFFSET_X: work_offset_x_q <= cfg_data_i;
        asi_pkg::CFG_WORK_OFFSET_Y: work_offset_y_q <= cfg_data_i;
        asi_pkg::CFG_SPEED_SCALE:   speed_scale_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  asi_pkg::cmd_t front_cmd, q_data;
  asi_pkg::cordic_req_t cor_req;
  asi_pkg::cordic_rsp_t cor_rsp;
  logic q_full, q_valid, q_pop;

  assign in_stall_o = q_full;

  // Front end: resolves end point and scaled feed as the item is accepted.
  asi_front u_front (
    .req_type_i      (req_type_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .word_x_i        (word_x_i),
    .word_y_i        (word_y_i),
    .has_x_i         (has_x_i),
    .has_y_i         (has_y_i),
    .off_i_i         (off_i_i),
    .off_j_i         (off_j_i),
    .clockwise_i     (clockwise_i),
    .feed_rate_i     (feed_rate_i),
    .absolute_mode_i (absolute_mode_q),
    .work_offset_x_i (work_offset_x_q),
    .work_offset_y_i (work_offset_y_q),
    .speed_scale_i   (speed_scale_q),
    .cmd_o           (front_cmd)
  );

  asi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  // One CORDIC serves both angle measurements and every point rotation.
  asi_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  asi_back #(
    .SEG_BITS (SEGMENT_COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_data_i          (q_data),
    .q_pop_o           (q_pop),
    .cor_req_o         (cor_req),
    .cor_rsp_i         (cor_rsp),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .point_x_o         (point_x_o),
    .point_y_o         (point_y_o),
    .move_feed_o       (move_feed_o),
    .last_point_o      (last_point_o),
    .linear_fallback_o (linear_fallback_o)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the arc segment interpolator: directed and random arcs.
// Depends on asi_pkg and arc_segment_interpolator_top; predicts every point internally.
`timescale 1ns / 1ps

module testbench;

  localparam int SEG_BITS = 16;
  localparam int CORDIC_STEPS = 24;
  // A start item may still be busy in the sequencer with nothing expected; this
  // covers its square root, two vectoring passes and the divide with margin.
  localparam int SETTLE_CYCLES = 300;

  typedef enum bit {REQ_START = 1'b0, REQ_TICK = 1'b1} req_e;

  typedef struct {
    req_e             kind;
    logic signed [31:0] start_x, start_y, word_x, word_y, off_i, off_j;
    logic             has_x, has_y, clockwise;
    logic [23:0]      feed;
  } cmd_item_t;

  typedef struct {
    logic signed [31:0] px, py;
    logic [31:0]        feed;
    logic               last, linear;
  } point_t;

  // Tracks arc state from accepted items and holds the points still due.
  class arc_scoreboard;
    longint arctan_q29[30] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
      8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
      4, 2, 1};
    longint pi_a = longint'(asi_pkg::ANG_PI);
    longint turn_a = longint'(asi_pkg::ANG_TWO_PI);
    longint quarter_a = longint'(asi_pkg::ANG_HALF_PI);

    bit abs_mode = 1;
    longint offs_x = 0, offs_y = 0;
    longint unsigned feed_scale = 256;

    bit active = 0;
    longint cen_x = 0, cen_y = 0, start_ang = 0, delta_ang = 0;
    longint unsigned radius = 0, feed_now = 0;
    int unsigned seg_done = 0, seg_count = 0;

    point_t pending_points[$];
    bit failed = 0;

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        asi_pkg::CFG_ABSOLUTE_MODE: abs_mode = data[0];
        asi_pkg::CFG_WORK_OFFSET_X: offs_x = longint'(signed'(data));
        asi_pkg::CFG_WORK_OFFSET_Y: offs_y = longint'(signed'(data));
        asi_pkg::CFG_SPEED_SCALE:   feed_scale = data[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[31:0];
    endfunction

    // Vectoring CORDIC: angle of (x, y), pre-rotated into the right half plane.
    function longint vec_angle(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = quarter_a;
        end else begin
          t = x; x = -y; y = t; z = -quarter_a;
        end
      end
      for (int k = 0; k < CORDIC_STEPS && k < 30; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y > 0) begin
          x += dx; y -= dy; z += arctan_q29[k];
        end else begin
          x -= dx; y += dy; z -= arctan_q29[k];
        end
      end
      if (z > pi_a) z = pi_a;
      if (z < -pi_a) z = -pi_a;
      return z;
    endfunction

    // Rotation CORDIC: point at angle ang on a circle of radius r about the origin.
    function void rotate(longint ang, longint unsigned r, output longint ox, output longint oy);
      longint x, y, dx, dy;
      longint unsigned scaled;
      scaled = (r * longint'(asi_pkg::INV_GAIN_Q30)) >> 30;
      x = longint'(scaled);
      y = 0;
      if (ang > quarter_a) begin
        y = x; x = 0; ang -= quarter_a;
      end else if (ang < -quarter_a) begin
        y = -x; x = 0; ang += quarter_a;
      end
      for (int k = 0; k < CORDIC_STEPS && k < 30; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (ang >= 0) begin
          x -= dx; y += dy; ang -= arctan_q29[k];
        end else begin
          x += dx; y -= dy; ang += arctan_q29[k];
        end
      end
      ox = x;
      oy = y;
    endfunction

    // Called for every accepted item, in acceptance order.
    function void note(cmd_item_t it);
      longint sx, sy, oi, oj, ex, ey, ea, diff, segs, ang, px, py;
      longint unsigned prod, adiff, sq;
      point_t p;
      if (it.kind == REQ_START) begin
        sx = it.start_x; sy = it.start_y; oi = it.off_i; oj = it.off_j;
        feed_now = ((longint'(it.feed) * feed_scale) >> 8) & 64'hFFFF_FFFF;
        if (abs_mode) begin
          ex = it.has_x ? clamp32(longint'(it.word_x) + offs_x) : sx;
          ey = it.has_y ? clamp32(longint'(it.word_y) + offs_y) : sy;
        end else begin
          ex = clamp32(sx + (it.has_x ? longint'(it.word_x) : 0));
          ey = clamp32(sy + (it.has_y ? longint'(it.word_y) : 0));
        end
        sq = longint'(oi * oi) + longint'(oj * oj);
        radius = root(sq);
        if (radius < asi_pkg::RADIUS_MIN) begin
          // Radius too small for an arc: one straight move to the end point.
          active = 0;
          p.px = ex[31:0]; p.py = ey[31:0]; p.feed = feed_now[31:0];
          p.last = 1; p.linear = 1;
          pending_points.push_back(p);
          return;
        end
        cen_x = clamp32(sx + oi);
        cen_y = clamp32(sy + oj);
        start_ang = vec_angle(-oj, -oi);
        ea = vec_angle(ey - cen_y, ex - cen_x);
        if (it.clockwise) begin
          if (ea >= start_ang) ea -= turn_a;
        end else begin
          if (ea <= start_ang) ea += turn_a;
        end
        diff = ea - start_ang;
        adiff = diff < 0 ? -diff : diff;
        prod = adiff * radius;
        segs = longint'((prod + ((64'd1 << 45) - 1)) >> 45);
        if (segs > (64'sd1 << SEG_BITS) - 1) segs = (64'sd1 << SEG_BITS) - 1;
        if (segs < 1) segs = 1;
        delta_ang = diff / segs;
        if (delta_ang > pi_a) delta_ang -= turn_a;
        if (delta_ang < -pi_a) delta_ang += turn_a;
        seg_count = segs;
        seg_done = 0;
        active = 1;
      end else if (active) begin
        seg_done++;
        ang = (start_ang + delta_ang * longint'(seg_done)) % turn_a;
        if (ang > pi_a) ang -= turn_a;
        if (ang < -pi_a) ang += turn_a;
        rotate(ang, radius, px, py);
        p.last = seg_done >= seg_count;
        if (p.last) active = 0;
        p.px = clamp32(cen_x + px);
        p.py = clamp32(cen_y + py);
        p.feed = feed_now[31:0];
        p.linear = 0;
        pending_points.push_back(p);
      end
    endfunction

    function void check(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        $error("point arrived with none expected: x %0d y %0d", got.px, got.py);
        failed = 1;
        return;
      end
      want = pending_points.pop_front();
      if (got.px !== want.px) begin
        $error("point_x expected %0d actual %0d", want.px, got.px); failed = 1;
      end
      if (got.py !== want.py) begin
        $error("point_y expected %0d actual %0d", want.py, got.py); failed = 1;
      end
      if (got.feed !== want.feed) begin
        $error("move_feed expected %0d actual %0d", want.feed, got.feed); failed = 1;
      end
      if (got.last !== want.last) begin
        $error("last_point expected %0d actual %0d", want.last, got.last); failed = 1;
      end
      if (got.linear !== want.linear) begin
        $error("linear_fallback expected %0d actual %0d", want.linear, got.linear);
        failed = 1;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic req_type_i = 0;
  logic signed [31:0] start_x_i = '0, start_y_i = '0, word_x_i = '0, word_y_i = '0;
  logic signed [31:0] off_i_i = '0, off_j_i = '0;
  logic has_x_i = 0, has_y_i = 0, clockwise_i = 0;
  logic [23:0] feed_rate_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [31:0] point_x_o, point_y_o;
  logic [31:0] move_feed_o;
  logic last_point_o, linear_fallback_o;

  arc_scoreboard arcs = new();
  // Percentage of items sent after an idle gap, and of cycles in which the receiver stalls.
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  always #1 clk_i = ~clk_i;

  arc_segment_interpolator_top #(
    .SEGMENT_COUNT_BITS(SEG_BITS),
    .CORDIC_ITERATIONS(CORDIC_STEPS)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .start_x_i, .start_y_i,
    .word_x_i, .word_y_i, .has_x_i, .has_y_i, .off_i_i, .off_j_i,
    .clockwise_i, .feed_rate_i, .out_valid_o, .out_stall_i,
    .point_x_o, .point_y_o, .move_feed_o, .last_point_o, .linear_fallback_o
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Every point the block hands over is checked against the oldest expected one.
  always @(posedge clk_i) begin
    point_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.px = point_x_o; got.py = point_y_o; got.feed = move_feed_o;
      got.last = last_point_o; got.linear = linear_fallback_o;
      arcs.check(got);
    end
  end

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic send(cmd_item_t it);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    req_type_i <= it.kind;
    start_x_i <= it.start_x; start_y_i <= it.start_y;
    word_x_i <= it.word_x; word_y_i <= it.word_y;
    has_x_i <= it.has_x; has_y_i <= it.has_y;
    off_i_i <= it.off_i; off_j_i <= it.off_j;
    clockwise_i <= it.clockwise; feed_rate_i <= it.feed;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    arcs.note(it);
    items_sent++;
  endtask

  // Drops valid and waits until every expected point is out and the sequencer is quiet.
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (arcs.pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
    arcs.write_reg(idx, data);
  endtask

  function automatic cmd_item_t make_cmd(req_e kind, int sx, int sy, int wx, int wy,
                                         bit hx, bit hy, int oi, int oj, bit cw);
    cmd_item_t it;
    it.kind = kind;
    it.start_x = sx; it.start_y = sy; it.word_x = wx; it.word_y = wy;
    it.has_x = hx; it.has_y = hy; it.off_i = oi; it.off_j = oj;
    it.clockwise = cw;
    it.feed = $urandom_range(0, 24'hFFFFFF);
    return it;
  endfunction

  function automatic cmd_item_t tick_cmd();
    cmd_item_t it;
    it = make_cmd(REQ_TICK, $urandom, $urandom, $urandom, $urandom, $urandom_range(1),
                  $urandom_range(1), $urandom, $urandom, $urandom_range(1));
    return it;
  endfunction

  // Mostly plausible plotter arcs of a few millimeters, some tiny radii and some
  // fully random commands; then a run of ticks that usually finishes the arc.
  task automatic random_arc();
    cmd_item_t it;
    int kind_pick, total, n, mm_offset;
    kind_pick = $urandom_range(9);
    mm_offset = (kind_pick < 2) ? 4000 : (5 << 16);
    if (kind_pick == 9) begin
      it = make_cmd(REQ_START, $urandom, $urandom, $urandom, $urandom, $urandom_range(1),
                    $urandom_range(1), $urandom, $urandom, $urandom_range(1));
    end else begin
      it = make_cmd(REQ_START,
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    int'($urandom_range(0, 200 << 16)) - (100 << 16),
                    $urandom_range(1), $urandom_range(1),
                    int'($urandom_range(0, 2 * mm_offset)) - mm_offset,
                    int'($urandom_range(0, 2 * mm_offset)) - mm_offset,
                    $urandom_range(1));
    end
    send(it);
    total = arcs.active ? arcs.seg_count : 0;
    kind_pick = $urandom_range(9);
    if (total > 40) n = $urandom_range(1, 5);
    else if (kind_pick < 7) n = total;
    else if (kind_pick == 7) n = $urandom_range(0, total);
    else n = total + $urandom_range(1, 2);
    repeat (n) send(tick_cmd());
  endtask

  initial begin
    logic [31:0] offsets[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0003_8000};
    logic [31:0] scales[4] = '{32'h0000_FFFF, 32'h0000_0000, 32'h0000_0100, 32'h0000_0180};
    int idle_plan[4] = '{0, 74, 0, 14};
    int stall_plan[4] = '{0, 0, 74, 14};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part with reset configuration: absolute mode, no offset, unit scale.
    send(tick_cmd());                                              // tick with no arc
    send(make_cmd(REQ_START, 0, 0, 0, 0, 0, 0, 0, 0, 0));          // zero radius
    send(make_cmd(REQ_START, 5 << 16, 0, 1 << 16, 1 << 16, 1, 1, 6553, 0, 1)); // just under
    send(make_cmd(REQ_START, 0, 0, 0, 0, 0, 0, 6554, 0, 0));       // smallest arc radius
    send(tick_cmd());
    // Full circles: end equal to start, both directions.
    send(make_cmd(REQ_START, 1 << 16, 2 << 16, 0, 0, 0, 0, 1 << 16, 0, 1));
    repeat (8) send(tick_cmd());
    send(make_cmd(REQ_START, 1 << 16, 2 << 16, 0, 0, 0, 0, 0, -(1 << 16), 0));
    repeat (3) send(tick_cmd());
    // New start while an arc is in progress; its end lies on the centre.
    send(make_cmd(REQ_START, 0, 0, 2 << 16, 0, 1, 1, 2 << 16, 0, 0));
    send(tick_cmd());
    // Saturating centre, end point at the extremes of the range, largest radius and feed.
    begin
      cmd_item_t it;
      it = make_cmd(REQ_START, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
      it.feed = 24'hFFFFFF;
      send(it);
      send(tick_cmd());
      send(tick_cmd());
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      // Configuration changes only with the block idle.
      write_cfg(asi_pkg::CFG_ABSOLUTE_MODE, phase % 2);
      write_cfg(asi_pkg::CFG_WORK_OFFSET_X, offsets[phase]);
      write_cfg(asi_pkg::CFG_WORK_OFFSET_Y, offsets[(phase + 1) % 4]);
      write_cfg(asi_pkg::CFG_SPEED_SCALE, scales[phase]);
      sender_idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      while (items_sent < 25 + 200 * (phase + 1)) random_arc();
      // Hold the sender until everything in flight has come out.
      drain();
    end

    stall_pct = 0;
    if (!arcs.failed && arcs.pending_points.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== arc_segment_interpolator_top.f =====
src/asi_pkg.sv
src/asi_front.sv
src/asi_queue.sv
src/asi_cordic.sv
src/asi_back.sv
src/arc_segment_interpolator_top.sv
sim/testbench.sv
